// ===== hw/rtl/tlp_pkg.sv =====
// package: sizes, payload words, queue command and helpers of the perceptron core
`timescale 1ns / 1ps
package tlp_pkg;

    localparam int INPUTS    = 7;
    localparam int HIDDEN    = 4;
    localparam int OUTPUTS   = 3;
    localparam int FRAC_BITS = 10;

    localparam int HID_WEIGHTS  = INPUTS * HIDDEN;
    localparam int OUT_FANIN    = HIDDEN + 1;
    localparam int WEIGHT_COUNT = HID_WEIGHTS + OUTPUTS * OUT_FANIN;
    localparam int MAX_FANIN    = (INPUTS > OUT_FANIN) ? INPUTS : OUT_FANIN;
    localparam int MAX_NEURONS  = (HIDDEN > OUTPUTS) ? HIDDEN : OUTPUTS;

    localparam int WADDR_W = $clog2(WEIGHT_COUNT);
    localparam int FADDR_W = $clog2(INPUTS);
    localparam int HADDR_W = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
    localparam int NEUR_W  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int K_W     = $clog2(MAX_FANIN);
    localparam int ACC_W   = 33 + $clog2(MAX_FANIN);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [15:0] FIX_ONE = 16'(1 << FRAC_BITS);

    localparam logic OP_WEIGHT  = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [5:0]        weight_index;
        logic [2:0]        feature_index;
        logic signed [15:0] value;
        logic              start_req;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  out_index;
        logic [14:0] out_value;
        logic        out_last;
    } t_out_word;

    typedef struct packed {
        logic               wr_weight;
        logic               wr_feature;
        logic               run;
        logic [WADDR_W-1:0] waddr;
        logic [FADDR_W-1:0] faddr;
        logic signed [15:0] value;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_WAIT
    } t_back_state;

    function automatic logic [14:0] relu_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        logic [14:0]             res;
        sh = acc >>> FRAC_BITS;
        if (sh[ACC_W-1]) begin
            res = 15'd0;
        end else if (|sh[ACC_W-2:15]) begin
            res = 15'h7fff;
        end else begin
            res = sh[14:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/tlp_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module tlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 43
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/tlp_front.sv =====
// front end: accepts input words and turns them into back-end commands
`timescale 1ns / 1ps
module tlp_front import tlp_pkg::*; (
    input  logic     i_valid,
    input  t_in_word i_word,
    input  logic     i_full,
    output logic     o_stall,
    output logic     o_push,
    output t_cmd     o_cmd
);

    always_comb begin
        o_cmd.wr_weight  = (i_word.operation == OP_WEIGHT) &&
                           (32'(i_word.weight_index) < WEIGHT_COUNT);
        o_cmd.wr_feature = (i_word.operation == OP_FEATURE) &&
                           (32'(i_word.feature_index) < INPUTS);
        o_cmd.run        = (i_word.operation == OP_FEATURE) && i_word.start_req;
        o_cmd.waddr      = WADDR_W'(i_word.weight_index);
        o_cmd.faddr      = FADDR_W'(i_word.feature_index);
        o_cmd.value      = i_word.value;
    end

    assign o_push  = i_valid && (o_cmd.wr_weight || o_cmd.wr_feature || o_cmd.run);
    assign o_stall = i_full;

endmodule

// ===== hw/rtl/tlp_queue.sv =====
// short command queue between front and back end
`timescale 1ns / 1ps
module tlp_queue import tlp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push, pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/tlp_back.sv =====
// back end: weight and feature stores, shared multiply-accumulate and result register
`timescale 1ns / 1ps
module tlp_back import tlp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    t_back_state        r_state, n_state;
    logic               r_layer, n_layer;
    logic [NEUR_W-1:0]  r_neuron, n_neuron;
    logic [K_W-1:0]     r_k, n_k;
    logic [WADDR_W-1:0] r_waddr, n_waddr;
    logic               r_p1, n_p1;
    logic               r_p2, n_p2;
    logic signed [15:0] r_opa, n_opa;
    logic signed [31:0] r_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic signed [15:0] r_feature [INPUTS];
    logic [14:0]        r_hidden  [HIDDEN];

    logic               ram_wr_en;
    logic [15:0]        ram_rd_data;
    logic               last_k;
    logic               out_free;
    logic [14:0]        reduced;
    logic               hid_wr_en;

    tlp_ram #(
        .WIDTH (16),
        .DEPTH (WEIGHT_COUNT)
    ) u_weight_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (i_cmd.waddr),
        .i_wr_data (i_cmd.value),
        .i_rd_addr (r_waddr),
        .o_rd_data (ram_rd_data)
    );

    assign o_pop     = (r_state == S_IDLE) && i_cmd_valid;
    assign ram_wr_en = o_pop && i_cmd.wr_weight;
    assign last_k    = r_layer ? (r_k == K_W'(HIDDEN)) : (r_k == K_W'(INPUTS - 1));
    assign out_free  = !r_out_valid || !i_stall;
    assign reduced   = relu_sat(r_acc);
    assign o_valid   = r_out_valid;
    assign o_word    = r_out_word;

    always_comb begin
        n_state     = r_state;
        n_layer     = r_layer;
        n_neuron    = r_neuron;
        n_k         = r_k;
        n_waddr     = r_waddr;
        n_p1        = 1'b0;
        n_p2        = r_p1;
        n_opa       = r_opa;
        n_acc       = r_p2 ? r_acc + ACC_W'(r_prod) : r_acc;
        n_out_valid = r_out_valid && i_stall;
        n_out_word  = r_out_word;
        hid_wr_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (o_pop && i_cmd.run) begin
                    n_state  = S_MAC;
                    n_layer  = 1'b0;
                    n_neuron = '0;
                    n_k      = '0;
                    n_waddr  = '0;
                    n_acc    = '0;
                end
            end
            S_MAC: begin
                n_p1    = 1'b1;
                n_waddr = r_waddr + 1'b1;
                if (!r_layer) begin
                    n_opa = r_feature[r_k[FADDR_W-1:0]];
                end else if (r_k == '0) begin
                    n_opa = FIX_ONE;
                end else begin
                    n_opa = $signed({1'b0, r_hidden[HADDR_W'(r_k - 1'b1)]});
                end
                if (last_k) begin
                    n_k     = '0;
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_WAIT: begin
                if (!r_p1 && !r_p2) begin
                    if (!r_layer) begin
                        hid_wr_en = 1'b1;
                        n_acc     = '0;
                        n_state   = S_MAC;
                        if (r_neuron == NEUR_W'(HIDDEN - 1)) begin
                            n_layer  = 1'b1;
                            n_neuron = '0;
                        end else begin
                            n_neuron = r_neuron + 1'b1;
                        end
                    end else if (out_free) begin
                        n_out_valid          = 1'b1;
                        n_out_word.out_index = 2'(r_neuron);
                        n_out_word.out_value = reduced;
                        n_out_word.out_last  = (r_neuron == NEUR_W'(OUTPUTS - 1));
                        n_acc                = '0;
                        if (r_neuron == NEUR_W'(OUTPUTS - 1)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_neuron = r_neuron + 1'b1;
                            n_state  = S_MAC;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_layer     <= 1'b0;
            r_neuron    <= '0;
            r_k         <= '0;
            r_waddr     <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_layer     <= n_layer;
            r_neuron    <= n_neuron;
            r_k         <= n_k;
            r_waddr     <= n_waddr;
            r_p1        <= n_p1;
            r_p2        <= n_p2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opa      <= n_opa;
        r_prod     <= r_opa * $signed(ram_rd_data);
        r_acc      <= n_acc;
        r_out_word <= n_out_word;
        if (o_pop && i_cmd.wr_feature) begin
            r_feature[i_cmd.faddr] <= i_cmd.value;
        end
        if (hid_wr_en) begin
            r_hidden[HADDR_W'(r_neuron)] <= reduced;
        end
    end

`ifndef SYNTHESIS
    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1 |=> r_p2)
        else $error("mac pipeline lost a product");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_p1 && !r_p2))
        else $error("mac pipeline busy while idle");
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.out_last) |-> (r_out_word.out_index == 2'(OUTPUTS - 1)))
        else $error("last flag on wrong neuron");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled result dropped");
`endif

endmodule

// ===== hw/rtl/two_layer_perceptron_inference_core.sv =====
// a weight or feature word waits in the two-entry queue until popped in S_IDLE
// a run computes hidden neurons, then output neurons with a bias, one at a time
// throughput: the single shared multiply-accumulate, one weight a cycle in S_MAC
// results wait in an output register while new words still enter the queue
// reset: synchronous active low, clears queue, sequencer and result valid
// weight, feature and hidden stores are not cleared
`timescale 1ns / 1ps
module two_layer_perceptron_inference_core import tlp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    logic front_push;
    t_cmd front_cmd;
    logic queue_full;
    logic queue_valid;
    t_cmd queue_cmd;
    logic back_pop;

    tlp_front u_front (
        .i_valid (i_valid),
        .i_word  (i_word),
        .i_full  (queue_full),
        .o_stall (o_stall),
        .o_push  (front_push),
        .o_cmd   (front_cmd)
    );

    tlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    tlp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_pop       (back_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word)
    );

endmodule
